### src/arcade_protection_sequencer_assert.svh
// Assertion macros used by the protection sequencer top level.
`ifndef ARCADE_PROTECTION_SEQUENCER_ASSERT_SVH
`define ARCADE_PROTECTION_SEQUENCER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define APS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define APS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/aps_pkg.sv
// Package with the types, constants and table functions of the protection sequencer.
`timescale 1ns / 1ps

package aps_pkg;

	// Access kind carried by the cmd field.
	typedef enum logic {
		CMD_READ  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	// Values written to the control address that change the sequencer state.
	typedef enum logic [7:0] {
		CTRL_OFF = 8'h00,
		CTRL_ON  = 8'h01
	} ctrl_val_t;

	localparam logic [14:0] CtrlAddr  = 15'h5004;
	// Upper ten address bits of the two 64-byte read windows.
	localparam logic [9:0]  WinABase  = 10'h142;
	localparam logic [9:0]  WinBBase  = 10'h143;
	localparam logic [5:0]  TickWrap  = 6'd60;
	localparam logic [4:0]  StepWrap  = 5'd30;

	// Fixed bytes and upper bits returned while protection is off.
	localparam logic [1:0]  OffHiA40  = 2'b01;
	localparam logic [1:0]  OffHiAC0  = 2'b11;
	localparam logic [7:0]  OffB00    = 8'h1f;
	localparam logic [7:0]  OffB09    = 8'h30;
	localparam logic [7:0]  OffB0c    = 8'h00;
	localparam logic [7:0]  OffBDef   = 8'h20;

	// Odd-entry table; offsets past the end read as entry zero.
	function automatic logic [7:0] odd_entry(input logic [4:0] idx);
		logic [7:0] r;
		case (idx) inside
			5'd1, 5'd4, 5'd7, 5'd11, 5'd14, 5'd17, 5'd21, 5'd24, 5'd27: r = 8'hc0;
			5'd3, 5'd5, 5'd9, 5'd13, 5'd15, 5'd19, 5'd23, 5'd25, 5'd29: r = 8'h40;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Even-entry table; offsets past the end read as entry zero.
	function automatic logic [7:0] even_entry(input logic [4:0] idx);
		logic [7:0] r;
		case (idx)
			5'd0:  r = 8'h1f;
			5'd1:  r = 8'h3f;
			5'd2:  r = 8'h2f;
			5'd3:  r = 8'h2f;
			5'd4:  r = 8'h0f;
			5'd5:  r = 8'h0f;
			5'd6:  r = 8'h0f;
			5'd7:  r = 8'h3f;
			5'd8:  r = 8'h0f;
			5'd9:  r = 8'h0f;
			5'd10: r = 8'h1c;
			5'd11: r = 8'h3c;
			5'd12: r = 8'h2c;
			5'd13: r = 8'h2c;
			5'd14: r = 8'h0c;
			5'd15: r = 8'h0c;
			5'd16: r = 8'h0c;
			5'd17: r = 8'h3c;
			5'd18: r = 8'h0c;
			5'd19: r = 8'h0c;
			5'd20: r = 8'h11;
			5'd21: r = 8'h31;
			5'd22: r = 8'h21;
			5'd23: r = 8'h21;
			5'd24: r = 8'h01;
			5'd25: r = 8'h01;
			5'd26: r = 8'h01;
			5'd27: r = 8'h31;
			5'd28: r = 8'h01;
			5'd29: r = 8'h01;
			default: r = 8'h1f;
		endcase
		return r;
	endfunction

endpackage

### src/arcade_protection_sequencer.sv
// Top level of the bus copy-protection sequencer.
`timescale 1ns / 1ps
`include "arcade_protection_sequencer_assert.svh"

// An accepted word is held in the input register and moves into the result register when
// that register can take it; the tick counter and table offset update at the edge that loads it.
// Throughput: one word per cycle while out_ready is high; a stalled result holds in_ready
// low once the input register is also full.
// Reset (arst_n low, asynchronous) empties both registers, turns protection on, clears the
// tick counter, the table offset and the DIP switch register.
module arcade_protection_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic        hit,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import aps_pkg::*;

	logic        valid_s1;
	logic        cmd_s1;
	logic [15:0] addr_s1;
	logic [7:0]  val_s1;
	logic        out_valid_q;
	logic [7:0]  read_data_q;
	logic        hit_q;
	logic [7:0]  dip_q;
	logic [5:0]  tick_q;
	logic [4:0]  step_q;
	logic        prot_off_q;

	logic        advance;
	logic        in_accept;
	logic        ctrl_hit;
	logic        win_a;
	logic        win_b;
	logic [5:0]  off;
	logic [7:0]  data_a;
	logic [7:0]  data_b;
	logic [7:0]  data_d;
	logic        hit_d;
	logic [5:0]  tick_inc;
	logic [4:0]  step_inc;
	logic [5:0]  tick_d;
	logic [4:0]  step_d;
	logic        prot_off_d;
	logic        off_move;
	logic        seq_cleared;

	// Handshakes: the input register moves on whenever the result register can take a word.
	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign in_accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dip_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			dip_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1  <= cmd;
			addr_s1 <= bus_address;
			val_s1  <= write_value;
		end
	end

	// Address decode of the stored word.
	assign ctrl_hit = (cmd_s1 == CMD_WRITE) && (addr_s1[14:0] == CtrlAddr);
	assign win_a    = (cmd_s1 == CMD_READ) && (addr_s1[15:6] == WinABase);
	assign win_b    = (cmd_s1 == CMD_READ) && (addr_s1[15:6] == WinBBase);
	assign off      = addr_s1[5:0];

	// First window: table byte or fixed upper bits, merged with the switches.
	always_comb begin
		if (!prot_off_q) begin
			data_a = odd_entry(step_q) | {2'b00, dip_q[5:0]};
		end else begin
			case (off) inside
				6'h01, 6'h04:        data_a = {OffHiA40, dip_q[5:0]};
				6'h05, 6'h0e, 6'h10: data_a = {OffHiAC0, dip_q[5:0]};
				default:             data_a = {2'b00, dip_q[5:0]};
			endcase
		end
	end

	// Second window: table byte, or fixed bytes when unprotected.
	always_comb begin
		if (!prot_off_q) begin
			data_b = even_entry(step_q);
		end else begin
			case (off)
				6'h00:   data_b = OffB00;
				6'h09:   data_b = OffB09;
				6'h0c:   data_b = OffB0c;
				default: data_b = OffBDef;
			endcase
		end
	end

	// Result selection.
	always_comb begin
		data_d = 8'h00;
		hit_d  = 1'b0;
		if (ctrl_hit) begin
			hit_d = 1'b1;
		end else if (win_a) begin
			data_d = data_a;
			hit_d  = 1'b1;
		end else if (win_b) begin
			data_d = data_b;
			hit_d  = 1'b1;
		end
	end

	// Sequencer update for control writes.
	assign tick_inc = tick_q + 6'd1;
	assign step_inc = step_q + 5'd1;

	always_comb begin
		tick_d     = tick_q;
		step_d     = step_q;
		prot_off_d = prot_off_q;
		if (ctrl_hit) begin
			if (val_s1 == CTRL_OFF) begin
				tick_d     = '0;
				step_d     = '0;
				prot_off_d = 1'b1;
			end else if (val_s1 == CTRL_ON) begin
				prot_off_d = 1'b0;
				tick_d     = tick_inc;
				if (tick_inc >= TickWrap) begin
					tick_d = '0;
					step_d = (step_inc >= StepWrap) ? 5'd0 : step_inc;
				end
			end
		end
	end

	// Sequencer state changes when the stored word moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= '0;
			step_q     <= '0;
			prot_off_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			tick_q     <= tick_d;
			step_q     <= step_d;
			prot_off_q <= prot_off_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			read_data_q <= data_d;
			hit_q       <= hit_d;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign hit       = hit_q;

	// A disabling write that leaves the input register, and the cleared sequencer state.
	assign off_move    = valid_s1 && advance && ctrl_hit && (val_s1 == CTRL_OFF);
	assign seq_cleared = prot_off_q && (tick_q == 6'd0) && (step_q == 5'd0);

	// Checks on the sequencer state and the result path.
	`APS_ASSERT_ALWAYS(a_tick_range, tick_q < TickWrap, "tick counter out of range")
	`APS_ASSERT_ALWAYS(a_step_range, step_q < StepWrap, "table offset out of range")
	`APS_ASSERT_ALWAYS(a_miss_zero, !out_valid_q || hit_q || (read_data_q == 8'h00), "miss with data")
	`APS_ASSERT_NEXT(a_ctrl_off, off_move, seq_cleared, "disable write not applied")
	`APS_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(addr_s1), "stalled word lost")

endmodule
